[sv/shd_pkg.sv]
package shd_pkg;

  localparam logic [7:0] SYNC_B0 = 8'hF1;
  localparam logic [7:0] SYNC_B1 = 8'hA5;
  localparam logic [7:0] SYNC_B2 = 8'hC3;

  // register indexes on the configuration port
  localparam logic [1:0] REG_LONG_TYPE   = 2'd0;
  localparam logic [1:0] REG_SHORT_FIRST = 2'd1;
  localparam logic [1:0] REG_SHORT_LAST  = 2'd2;

  // hunt_step code for a completed sync sequence
  localparam logic [1:0] SYNC_DONE = 2'd3;

  localparam int QDEPTH = 4;
  localparam int QAW    = $clog2(QDEPTH);
  localparam int QCW    = $clog2(QDEPTH + 1);

  typedef struct packed {
    logic [3:0] long_type_code;
    logic [3:0] short_type_first;
    logic [3:0] short_type_last;
  } cfg_t;

  typedef struct packed {
    logic [7:0] frame_byte;
    logic [3:0] frame_kind;
    logic [9:0] frame_size;
    logic       empty_marker;
    logic       frame_end;
  } res_t;

  // results of one accepted byte: 0, 1 or 2 of them
  typedef struct packed {
    logic [1:0]      n;
    res_t [1:0]      res;
  } push_t;

  typedef struct packed {
    logic [QCW-1:0] count;
    logic           can_take;
  } q_stat_t;

  // one byte of the sync hunt; SYNC_DONE when F1 A5 C3 has just completed
  function automatic logic [1:0] hunt_step(input logic [1:0] prog, input logic [7:0] b);
    logic [1:0] restart;
    restart = (b == SYNC_B0) ? 2'd1 : 2'd0;
    case (prog)
      2'd1:    hunt_step = (b == SYNC_B1) ? 2'd2 : restart;
      2'd2:    hunt_step = (b == SYNC_B2) ? SYNC_DONE : restart;
      default: hunt_step = restart;
    endcase
  endfunction

endpackage

[sv/shd_if.sv]
interface shd_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] rx_byte;

  modport source (output valid, output rx_byte, input ready);
  modport sink   (input valid, input rx_byte, output ready);
endinterface

interface shd_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] frame_byte;
  logic [3:0] frame_kind;
  logic [9:0] frame_size;
  logic       empty_marker;
  logic       frame_end;

  modport source (output valid, output frame_byte, output frame_kind, output frame_size,
                  output empty_marker, output frame_end, input ready);
  modport sink   (input valid, input frame_byte, input frame_kind, input frame_size,
                  input empty_marker, input frame_end, output ready);
endinterface

[sv/shd_parser.sv]
module shd_parser (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          acc,
  input  logic [7:0]    rx_byte,
  input  shd_pkg::cfg_t cfg,
  output shd_pkg::push_t push,
  output logic [1:0]    phase
);
  import shd_pkg::*;

  typedef enum logic [1:0] {PH_HUNT, PH_HDR0, PH_HDR1, PH_BODY} phase_t;

  phase_t     phase_r, phase_nxt;
  logic [1:0] prog_r, prog_nxt;
  logic [7:0] hdr0_r, hdr0_nxt;
  logic [3:0] kind_r, kind_nxt;
  logic [9:0] size_r, size_nxt;
  logic [9:0] left_r, left_nxt;

  logic [1:0] h;
  logic [3:0] kind;
  logic [9:0] len;

  always_comb begin
    phase_nxt = phase_r;
    prog_nxt  = prog_r;
    hdr0_nxt  = hdr0_r;
    kind_nxt  = kind_r;
    size_nxt  = size_r;
    left_nxt  = left_r;
    push      = '0;
    h         = 2'd0;
    kind      = hdr0_r[7:4];
    if (kind == cfg.long_type_code) begin
      len = {hdr0_r[3:0], rx_byte[7:2]};
    end else if (kind inside {[cfg.short_type_first:cfg.short_type_last]}) begin
      len = {3'd0, hdr0_r[3:0], rx_byte[7:5]};
    end else begin
      len = '0;
    end

    if (acc) begin
      case (phase_r)
        PH_HDR0: begin
          hdr0_nxt  = rx_byte;
          phase_nxt = PH_HDR1;
        end
        PH_HDR1: begin
          kind_nxt  = kind;
          size_nxt  = len;
          phase_nxt = PH_HUNT;
          prog_nxt  = 2'd0;
          push.res[0].frame_kind = kind;
          push.res[0].frame_size = len;
          push.res[1].frame_kind = kind;
          push.res[1].frame_size = len;
          if (len == 10'd0) begin
            // empty frame: both header bytes go back to the sync hunt
            push.n = 2'd1;
            push.res[0].empty_marker = 1'b1;
            push.res[0].frame_end    = 1'b1;
            prog_nxt = hunt_step(hunt_step(2'd0, hdr0_r), rx_byte);
          end else if (len == 10'd1) begin
            push.n = 2'd1;
            push.res[0].frame_byte = hdr0_r;
            push.res[0].frame_end  = 1'b1;
            prog_nxt = hunt_step(2'd0, rx_byte);
          end else begin
            push.n = 2'd2;
            push.res[0].frame_byte = hdr0_r;
            push.res[1].frame_byte = rx_byte;
            push.res[1].frame_end  = (len == 10'd2);
            left_nxt = len - 10'd2;
            if (len != 10'd2) phase_nxt = PH_BODY;
          end
        end
        PH_BODY: begin
          left_nxt = left_r - 10'd1;
          push.n = 2'd1;
          push.res[0].frame_byte = rx_byte;
          push.res[0].frame_kind = kind_r;
          push.res[0].frame_size = size_r;
          push.res[0].frame_end  = (left_nxt == 10'd0);
          if (left_nxt == 10'd0) begin
            phase_nxt = PH_HUNT;
            prog_nxt  = 2'd0;
          end
        end
        default: begin
          h = hunt_step(prog_r, rx_byte);
          if (h == SYNC_DONE) begin
            prog_nxt  = 2'd0;
            phase_nxt = PH_HDR0;
          end else begin
            prog_nxt = h;
          end
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= PH_HUNT;
      prog_r  <= 2'd0;
      hdr0_r  <= '0;
      kind_r  <= '0;
      size_r  <= '0;
      left_r  <= '0;
    end else begin
      phase_r <= phase_nxt;
      prog_r  <= prog_nxt;
      hdr0_r  <= hdr0_nxt;
      kind_r  <= kind_nxt;
      size_r  <= size_nxt;
      left_r  <= left_nxt;
    end
  end

  assign phase = phase_r;

endmodule

[sv/shd_outq.sv]
module shd_outq (
  input  logic             clk,
  input  logic             rst_n,
  input  shd_pkg::push_t   push,
  input  logic             pop,
  output shd_pkg::res_t    head,
  output shd_pkg::q_stat_t stat
);
  import shd_pkg::*;

  res_t [QDEPTH-1:0] mem_r;
  logic [QAW-1:0]    wr_ptr_r, wr_ptr_nxt;
  logic [QAW-1:0]    rd_ptr_r, rd_ptr_nxt;
  logic [QCW-1:0]    count_r, count_nxt;
  logic              popped;

  always_comb begin
    popped     = pop && (count_r != '0);
    wr_ptr_nxt = wr_ptr_r + QAW'(push.n);
    rd_ptr_nxt = rd_ptr_r + QAW'(popped);
    count_nxt  = count_r + QCW'(push.n) - QCW'(popped);
  end

  always_ff @(posedge clk) begin
    if (push.n != 2'd0) mem_r[wr_ptr_r] <= push.res[0];
    if (push.n == 2'd2) mem_r[wr_ptr_r + QAW'(1)] <= push.res[1];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  assign head          = mem_r[rd_ptr_r];
  assign stat.count    = count_r;
  // room for the two results a header byte may bring
  assign stat.can_take = (count_r <= QCW'(QDEPTH - 2));

endmodule

[sv/sync_header_deframer_top.sv]
// Byte-serial deframer: hunts for the sync F1 A5 C3, decodes the two header
// bytes that follow and streams the frame's bytes out with type, length and a
// last mark; a zero-length frame gives one empty marker. One byte is taken
// every cycle; the byte that completes a header may yield two results, which
// a four-entry output queue absorbs, so the input stalls only when the
// output side holds off. Results enter the queue as their byte is taken.
// Configuration writes take effect at the next decoded header.
module sync_header_deframer_top (
  input  logic            clk,
  input  logic            rst_n,
  shd_in_if.sink          in_ch,
  shd_out_if.source       out_ch,
  input  logic            cfg_we,
  input  logic [1:0]      cfg_index,
  input  logic [3:0]      cfg_data
);
  import shd_pkg::*;

  cfg_t    cfg_r;
  push_t   push;
  res_t    head;
  q_stat_t stat;
  logic    acc;
  logic [1:0] phase;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.long_type_code   <= 4'd1;
      cfg_r.short_type_first <= 4'd2;
      cfg_r.short_type_last  <= 4'd3;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_LONG_TYPE:   cfg_r.long_type_code   <= cfg_data;
        REG_SHORT_FIRST: cfg_r.short_type_first <= cfg_data;
        REG_SHORT_LAST:  cfg_r.short_type_last  <= cfg_data;
        default: ;
      endcase
    end
  end

  assign in_ch.ready = stat.can_take;
  assign acc         = in_ch.valid && stat.can_take;

  shd_parser u_parser (
    .clk     (clk),
    .rst_n   (rst_n),
    .acc     (acc),
    .rx_byte (in_ch.rx_byte),
    .cfg     (cfg_r),
    .push    (push),
    .phase   (phase)
  );

  shd_outq u_outq (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (push),
    .pop   (out_ch.ready),
    .head  (head),
    .stat  (stat)
  );

  assign out_ch.valid        = (stat.count != '0);
  assign out_ch.frame_byte   = head.frame_byte;
  assign out_ch.frame_kind   = head.frame_kind;
  assign out_ch.frame_size   = head.frame_size;
  assign out_ch.empty_marker = head.empty_marker;
  assign out_ch.frame_end    = head.frame_end;

  a_q_bound: assert property (@(posedge clk) disable iff (!rst_n)
    stat.count <= QCW'(QDEPTH))
    else $error("output queue overfilled");

  a_push_needs_request: assert property (@(posedge clk) disable iff (!rst_n)
    (push.n != 2'd0) |-> acc)
    else $error("result pushed without an accepted request");

  a_pair_from_header: assert property (@(posedge clk) disable iff (!rst_n)
    (push.n == 2'd2) |-> (phase == 2'd2))
    else $error("two results outside the second header byte");

  a_idle_stays_empty: assert property (@(posedge clk) disable iff (!rst_n)
    (stat.count == '0 && push.n == 2'd0) |=> !out_ch.valid)
    else $error("result appeared from an empty queue");

endmodule

[dv/frame_stream_checker.sv]
module frame_stream_checker
  import shd_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  shd_in_if          in_ch,
  shd_out_if         out_ch,
  input  logic       cfg_we,
  input  logic [1:0] cfg_index,
  input  logic [3:0] cfg_data,
  output int         mismatches,
  output int         pending
);
  timeunit 1ns;
  timeprecision 1ps;

  typedef enum logic [1:0] {HUNT, HEAD_HI, HEAD_LO, BODY} phase_e;

  // register copies
  logic [3:0] long_code;
  logic [3:0] short_lo;
  logic [3:0] short_hi;

  // deframer state
  logic [1:0] match_cnt;
  phase_e     phase;
  logic [7:0] head_hi;
  logic [3:0] cur_kind;
  logic [9:0] cur_size;
  logic [9:0] remaining;

  res_t expected_results[$];

  initial begin
    mismatches = 0;
    pending = 0;
  end

  function automatic void scan_sync(input logic [7:0] b);
    logic [1:0] fresh;
    fresh = (b == SYNC_B0) ? 2'd1 : 2'd0;
    case (match_cnt)
      2'd1: match_cnt = (b == SYNC_B1) ? 2'd2 : fresh;
      2'd2: begin
        if (b == SYNC_B2) begin
          match_cnt = 2'd0;
          phase = HEAD_HI;
        end else begin
          match_cnt = fresh;
        end
      end
      default: match_cnt = fresh;
    endcase
  endfunction

  function automatic void emit(input logic [7:0] b, input logic empty, input logic last);
    res_t r;
    r.frame_byte   = b;
    r.frame_kind   = cur_kind;
    r.frame_size   = cur_size;
    r.empty_marker = empty;
    r.frame_end    = last;
    expected_results.push_back(r);
  endfunction

  function automatic void decode_rx_byte(input logic [7:0] b);
    logic [15:0] word;
    logic [3:0]  kind;
    logic [9:0]  len;
    case (phase)
      HEAD_HI: begin
        head_hi = b;
        phase = HEAD_LO;
      end
      HEAD_LO: begin
        word = {head_hi, b};
        kind = word[15:12];
        len = '0;
        // long type takes priority over an overlapping short range
        if (kind == long_code)
          len = word[11:2];
        else if (kind >= short_lo && kind <= short_hi)
          len = {3'd0, word[11:5]};
        cur_kind = kind;
        cur_size = len;
        phase = HUNT;
        match_cnt = 2'd0;
        if (len == 10'd0) begin
          emit(8'd0, 1'b1, 1'b1);
          // header bytes go back through the sync hunt
          scan_sync(head_hi);
          scan_sync(b);
        end else if (len == 10'd1) begin
          emit(head_hi, 1'b0, 1'b1);
          scan_sync(b);
        end else begin
          emit(head_hi, 1'b0, 1'b0);
          emit(b, 1'b0, len == 10'd2);
          remaining = len - 10'd2;
          if (remaining != 10'd0) phase = BODY;
        end
      end
      BODY: begin
        if (remaining != 10'd0) remaining = remaining - 10'd1;
        emit(b, 1'b0, remaining == 10'd0);
        if (remaining == 10'd0) begin
          phase = HUNT;
          match_cnt = 2'd0;
        end
      end
      default: scan_sync(b);
    endcase
  endfunction

  always @(posedge clk) begin
    res_t want;
    if (!rst_n) begin
      long_code = 4'd1;
      short_lo = 4'd2;
      short_hi = 4'd3;
      match_cnt = 2'd0;
      phase = HUNT;
      head_hi = '0;
      cur_kind = '0;
      cur_size = '0;
      remaining = '0;
      expected_results.delete();
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          REG_LONG_TYPE:   long_code = cfg_data;
          REG_SHORT_FIRST: short_lo = cfg_data;
          REG_SHORT_LAST:  short_hi = cfg_data;
          default: ;
        endcase
      end
      // push before pop so a same-edge result still finds its expectation
      if (in_ch.valid && in_ch.ready) decode_rx_byte(in_ch.rx_byte);
      if (out_ch.valid && out_ch.ready) begin
        if (expected_results.size() == 0) begin
          $display("%0t: unexpected result byte %h kind %h size %0d empty %b end %b",
                   $time, out_ch.frame_byte, out_ch.frame_kind, out_ch.frame_size,
                   out_ch.empty_marker, out_ch.frame_end);
          mismatches++;
        end else begin
          want = expected_results.pop_front();
          if (out_ch.frame_byte !== want.frame_byte ||
              out_ch.frame_kind !== want.frame_kind ||
              out_ch.frame_size !== want.frame_size ||
              out_ch.empty_marker !== want.empty_marker ||
              out_ch.frame_end !== want.frame_end) begin
            $display("%0t: mismatch exp byte %h kind %h size %0d empty %b end %b",
                     $time, want.frame_byte, want.frame_kind, want.frame_size,
                     want.empty_marker, want.frame_end);
            $display("%0t:          got byte %h kind %h size %0d empty %b end %b",
                     $time, out_ch.frame_byte, out_ch.frame_kind, out_ch.frame_size,
                     out_ch.empty_marker, out_ch.frame_end);
            mismatches++;
          end
        end
      end
    end
    pending = expected_results.size();
  end

endmodule

[dv/sync_header_deframer_top_tb.sv]
module sync_header_deframer_top_tb;
  timeunit 1ns;
  timeprecision 1ps;
  import shd_pkg::*;

  localparam logic [1:0] REG_UNUSED = 2'd3;
  localparam int PHASE_BYTES = 75;

  logic       clk = 1'b0;
  logic       rst_n;
  logic       cfg_we;
  logic [1:0] cfg_index;
  logic [3:0] cfg_data;
  int         mismatches;
  int         pending;

  // stimulus-side view of the registers, used to size frames
  logic [3:0] long_code;
  logic [3:0] short_lo;
  logic [3:0] short_hi;
  bit         in_stall_en;
  bit         out_stall_en;
  int         bytes_sent;

  shd_in_if  in_ch();
  shd_out_if out_ch();

  sync_header_deframer_top DUT (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_ch     (in_ch),
    .out_ch    (out_ch),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  frame_stream_checker checker_i (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_ch      (in_ch),
    .out_ch     (out_ch),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .mismatches (mismatches),
    .pending    (pending)
  );

  always #1 clk = ~clk;

  always @(negedge clk) begin
    out_ch.ready <= !(out_stall_en && $urandom_range(99) < 34);
  end

  initial begin
    #1ms;
    $display("CHECK FAILED");
    $finish;
  end

  // called at a falling edge; returns at the falling edge after acceptance
  task automatic send_byte(input logic [7:0] b);
    while (in_stall_en && $urandom_range(99) < 34) begin
      in_ch.valid <= 1'b0;
      @(negedge clk);
    end
    in_ch.valid <= 1'b1;
    in_ch.rx_byte <= b;
    do @(posedge clk); while (!in_ch.ready);
    @(negedge clk);
    bytes_sent++;
  endtask

  task automatic send_sync();
    send_byte(SYNC_B0);
    send_byte(SYNC_B1);
    send_byte(SYNC_B2);
  endtask

  task automatic quiesce();
    in_ch.valid <= 1'b0;
    @(negedge clk);
    while (pending != 0) @(negedge clk);
    // a header byte yields nothing yet may still be in flight
    repeat (4) @(negedge clk);
  endtask

  task automatic write_reg(input logic [1:0] idx, input logic [3:0] val);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    @(negedge clk);
    cfg_we <= 1'b0;
    case (idx)
      REG_LONG_TYPE:   long_code = val;
      REG_SHORT_FIRST: short_lo = val;
      REG_SHORT_LAST:  short_hi = val;
      default: ;
    endcase
  endtask

  task automatic send_frame(input logic [3:0] kind, input int len, input bit cut);
    logic [15:0] word;
    logic [7:0]  b;
    int          eff;
    int          body;
    int          pre;
    word = {kind, 12'($urandom)};
    eff = 0;
    if (kind == long_code) begin
      word[11:2] = len[9:0];
      eff = int'(len[9:0]);
    end else if (kind >= short_lo && kind <= short_hi) begin
      word[11:5] = len[6:0];
      eff = int'(len[6:0]);
    end
    pre = $urandom_range(9);
    if (pre == 0) begin
      send_byte(SYNC_B0);
    end else if (pre == 1) begin
      send_byte(SYNC_B0);
      send_byte(SYNC_B1);
      send_byte(SYNC_B0);
    end
    send_sync();
    send_byte(word[15:8]);
    send_byte(word[7:0]);
    body = (eff > 2) ? eff - 2 : 0;
    if (cut) body = $urandom_range(body);
    for (int i = 0; i < body; i++) begin
      b = 8'($urandom);
      case ($urandom_range(29))
        0: b = SYNC_B0;
        1: b = SYNC_B1;
        2: b = SYNC_B2;
        default: ;
      endcase
      send_byte(b);
    end
  endtask

  task automatic random_frame();
    logic [3:0] kind;
    int         len;
    int         pick;
    pick = $urandom_range(99);
    if (pick < 45)
      kind = long_code;
    else if (pick < 80 && short_lo <= short_hi)
      kind = 4'($urandom_range(short_hi, short_lo));
    else
      kind = 4'($urandom_range(15));
    pick = $urandom_range(199);
    if (pick == 0)
      len = $urandom_range(1023, 128);
    else if (pick < 12)
      len = $urandom_range(127);
    else
      len = $urandom_range(12);
    send_frame(kind, len, $urandom_range(19) == 0);
  endtask

  task automatic random_traffic(input int nbytes);
    int stop_at;
    int pick;
    stop_at = bytes_sent + nbytes;
    while (bytes_sent < stop_at) begin
      pick = $urandom_range(99);
      if (pick < 75) begin
        random_frame();
      end else if (pick < 88) begin
        repeat ($urandom_range(6, 1)) send_byte(8'($urandom));
      end else begin
        // sync prefix ended by a random byte
        send_byte(SYNC_B0);
        if ($urandom_range(1)) send_byte(SYNC_B1);
        send_byte(8'($urandom));
      end
    end
  endtask

  initial begin
    in_ch.valid = 1'b0;
    in_ch.rx_byte = '0;
    out_ch.ready = 1'b0;
    cfg_we = 1'b0;
    cfg_index = REG_LONG_TYPE;
    cfg_data = '0;
    rst_n = 1'b0;
    long_code = 4'd1;
    short_lo = 4'd2;
    short_hi = 4'd3;
    in_stall_en = 1'b1;
    out_stall_en = 1'b1;
    bytes_sent = 0;
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // zero-length header F1 A5 is rescanned; C3 then completes a sync
    send_sync();
    send_byte(8'hF1);
    send_byte(8'hA5);
    send_byte(8'hC3);
    // short type, length one; trailing header byte goes back to the hunt
    send_byte(8'h20);
    send_byte(8'h20);
    // long type, length two
    send_sync();
    send_byte(8'h10);
    send_byte(8'h08);
    // long type, length five, sync pattern inside the body is just data
    send_sync();
    send_byte(8'h10);
    send_byte(8'h14);
    send_sync();
    // overlapped sync, short type length three, extreme byte values
    send_byte(8'hF1);
    send_sync();
    send_byte(8'h20);
    send_byte(8'h60);
    send_byte(8'hFF);
    send_byte(8'h00);

    random_traffic(PHASE_BYTES);

    // long code inside an all-covering short range
    quiesce();
    write_reg(REG_LONG_TYPE, 4'd0);
    write_reg(REG_SHORT_FIRST, 4'd0);
    write_reg(REG_SHORT_LAST, 4'd15);
    send_frame(4'd0, 1023, 1'b0);
    random_traffic(PHASE_BYTES);

    // empty short range, no stalls on either side
    quiesce();
    write_reg(REG_LONG_TYPE, 4'd15);
    write_reg(REG_SHORT_FIRST, 4'd15);
    write_reg(REG_SHORT_LAST, 4'd0);
    in_stall_en = 1'b0;
    out_stall_en = 1'b0;
    random_traffic(PHASE_BYTES);
    in_stall_en = 1'b1;
    out_stall_en = 1'b1;

    quiesce();
    write_reg(REG_UNUSED, 4'($urandom));
    write_reg(REG_LONG_TYPE, 4'd7);
    write_reg(REG_SHORT_FIRST, 4'd4);
    write_reg(REG_SHORT_LAST, 4'd10);
    random_traffic(PHASE_BYTES);

    quiesce();
    write_reg(REG_LONG_TYPE, 4'($urandom));
    write_reg(REG_SHORT_FIRST, 4'($urandom));
    write_reg(REG_SHORT_LAST, 4'($urandom));
    random_traffic(PHASE_BYTES);

    quiesce();
    write_reg(REG_LONG_TYPE, 4'd1);
    write_reg(REG_SHORT_FIRST, 4'd2);
    write_reg(REG_SHORT_LAST, 4'd3);
    random_traffic(PHASE_BYTES);

    in_ch.valid <= 1'b0;
    while (pending != 0) @(negedge clk);
    repeat (8) @(negedge clk);
    if (mismatches == 0 && pending == 0)
      $display("CHECK OK");
    else
      $display("CHECK FAILED");
    $finish;
  end

endmodule

[filelist.f]
sv/shd_pkg.sv
sv/shd_if.sv
sv/shd_parser.sv
sv/shd_outq.sv
sv/sync_header_deframer_top.sv
dv/frame_stream_checker.sv
dv/sync_header_deframer_top_tb.sv
